FILE: src/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometer compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_C1 = 3'd0;
  localparam logic [2:0] REG_C2 = 3'd1;
  localparam logic [2:0] REG_C3 = 3'd2;
  localparam logic [2:0] REG_C4 = 3'd3;
  localparam logic [2:0] REG_C5 = 3'd4;
  localparam logic [2:0] REG_C6 = 3'd5;

  // temperature break points in hundredths of a degree
  localparam int TEMP_REF  = 2000;
  localparam int TEMP_COLD = -1500;
  localparam int COLD_OFS  = TEMP_REF - TEMP_COLD;

  // output saturation limits
  localparam int TEMP_MAX  = 140000;
  localparam int TEMP_MIN  = -140000;
  localparam int PRESS_MAX = 67108863;
  localparam int PRESS_MIN = -67108864;

  // factory coefficients
  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } coef_t;

  // first-order results
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [18:0] q;      // temp minus reference, first order
    logic        [17:0] t2;     // dt squared over 2^31
    logic signed [35:0] off1;
    logic signed [34:0] sens1;
  } front_t;

  // second-order corrected results
  typedef struct packed {
    logic        [23:0] d1;
    logic signed [39:0] off;
    logic signed [39:0] sens;
    logic signed [18:0] temp;   // already saturated
  } corr_t;

endpackage

FILE: src/bsc_front.sv
// ----------------------------------------------------------------------------
// bsc_front
// First-order stages: dT, the three coefficient products and dT squared,
// then temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
module bsc_front import bsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  coef_t       coef,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] press_raw,
  input  logic [23:0] temp_raw,
  output logic        out_valid,
  input  logic        out_ready,
  output front_t      out_data
);

  logic [2:0] vld;
  logic [2:0] adv;

  // stage 1 registers
  logic        [23:0] d1_a;
  logic signed [24:0] dt_a;
  // stage 2 registers
  logic        [23:0] d1_b;
  logic signed [41:0] p6_b;
  logic signed [41:0] p4_b;
  logic signed [41:0] p3_b;
  logic signed [49:0] sq_b;

  // stage advance chain
  always_comb begin
    adv[2] = !vld[2] || out_ready;
    adv[1] = !vld[1] || adv[2];
    adv[0] = !vld[0] || adv[1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[2];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
    end
  end

  // stage 1: dt against shifted reference temperature
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d1_a <= press_raw;
      dt_a <= $signed({1'b0, temp_raw}) - $signed({1'b0, coef.c5, 8'b0});
    end
  end

  // stage 2: coefficient products and dt squared
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d1_b <= d1_a;
      p6_b <= dt_a * $signed({1'b0, coef.c6});
      p4_b <= dt_a * $signed({1'b0, coef.c4});
      p3_b <= dt_a * $signed({1'b0, coef.c3});
      sq_b <= dt_a * dt_a;
    end
  end

  // stage 3: scale products into temp, offset and sensitivity
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      out_data.d1    <= d1_b;
      out_data.q     <= $signed(p6_b[41:23]);
      out_data.t2    <= sq_b[48:31];
      out_data.off1  <= $signed({3'b0, coef.c2, 16'b0}) + $signed(p4_b[41:7]);
      out_data.sens1 <= $signed({4'b0, coef.c1, 15'b0}) + $signed(p3_b[41:8]);
    end
  end

endmodule

FILE: src/bsc_corr.sv
// ----------------------------------------------------------------------------
// bsc_corr
// Second-order stages: squares of the temperature distances, the cold and
// very cold correction terms, and the corrected offset, sensitivity and temp.
// ----------------------------------------------------------------------------
module bsc_corr import bsc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output corr_t  out_data
);

  logic [2:0] vld;
  logic [2:0] adv;

  // stage 1 registers
  front_t      f_a;
  logic [34:0] a_a;
  logic [34:0] b_a;
  logic        low_a;
  logic        vlow_a;
  // stage 2 registers
  logic        [23:0] d1_b;
  logic signed [35:0] off1_b;
  logic signed [34:0] sens1_b;
  logic        [37:0] off2_b;
  logic        [37:0] sens2_b;
  logic signed [20:0] temp_b;

  // combinational helpers
  logic signed [19:0] qb;
  logic signed [37:0] a_full;
  logic signed [39:0] b_full;
  logic        [37:0] five_a;
  logic        [37:0] seven_b;
  logic        [37:0] eleven_b;
  logic        [37:0] off2_n;
  logic        [37:0] sens2_n;
  logic signed [20:0] temp_n;

  // stage advance chain
  always_comb begin
    adv[2] = !vld[2] || out_ready;
    adv[1] = !vld[1] || adv[2];
    adv[0] = !vld[0] || adv[1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[2];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
    end
  end

  // squares of distance to reference and to the cold point
  always_comb begin
    qb     = 20'(in_data.q) + 20'(COLD_OFS);
    a_full = in_data.q * in_data.q;
    b_full = qb * qb;
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      f_a    <= in_data;
      a_a    <= a_full[34:0];
      b_a    <= b_full[34:0];
      low_a  <= in_data.q[18];
      vlow_a <= (in_data.q < -19'(COLD_OFS));
    end
  end

  // correction terms by shift and add
  always_comb begin
    five_a   = {3'b0, a_a} + {1'b0, a_a, 2'b0};
    seven_b  = {b_a, 3'b0} - {3'b0, b_a};
    eleven_b = {b_a, 3'b0} + {2'b0, b_a, 1'b0} + {3'b0, b_a};
    off2_n   = '0;
    sens2_n  = '0;
    temp_n   = 21'(f_a.q) + 21'(TEMP_REF);
    if (low_a) begin
      off2_n  = {1'b0, five_a[37:1]};
      sens2_n = {2'b0, five_a[37:2]};
      temp_n  = temp_n - $signed({3'b0, f_a.t2});
      if (vlow_a) begin
        off2_n  = off2_n + seven_b;
        sens2_n = sens2_n + {1'b0, eleven_b[37:1]};
      end
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d1_b    <= f_a.d1;
      off1_b  <= f_a.off1;
      sens1_b <= f_a.sens1;
      off2_b  <= off2_n;
      sens2_b <= sens2_n;
      temp_b  <= temp_n;
    end
  end

  // stage 3: apply corrections, saturate temperature
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      out_data.d1   <= d1_b;
      out_data.off  <= 40'(off1_b) - $signed({2'b0, off2_b});
      out_data.sens <= 40'(sens1_b) - $signed({2'b0, sens2_b});
      if (temp_b > 21'(TEMP_MAX)) begin
        out_data.temp <= 19'(TEMP_MAX);
      end else if (temp_b < 21'(TEMP_MIN)) begin
        out_data.temp <= 19'(TEMP_MIN);
      end else begin
        out_data.temp <= temp_b[18:0];
      end
    end
  end

endmodule

FILE: src/bsc_press.sv
// ----------------------------------------------------------------------------
// bsc_press
// Pressure stages: D1 times sensitivity as two partial products, the
// 64-bit sum, offset removal and saturation into the output register.
// ----------------------------------------------------------------------------
module bsc_press import bsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  corr_t              in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [18:0] temperature_centi,
  output logic signed [26:0] pressure_pa
);

  logic [3:0] vld;
  logic [3:0] adv;

  // stage 1 registers
  logic        [43:0] lo_a;
  logic signed [44:0] hi_a;
  logic signed [39:0] off_a;
  logic signed [18:0] temp_a;
  // stage 2 registers
  logic signed [42:0] ps_b;
  logic signed [39:0] off_b;
  logic signed [18:0] temp_b;
  // stage 3 registers
  logic signed [28:0] xp_c;
  logic signed [18:0] temp_c;

  logic        [63:0] prod;
  logic signed [43:0] x_n;

  // stage advance chain
  always_comb begin
    adv[3] = !vld[3] || out_ready;
    adv[2] = !vld[2] || adv[3];
    adv[1] = !vld[1] || adv[2];
    adv[0] = !vld[0] || adv[1];
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[3];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
    end
  end

  // stage 1: partial products over low and high halves of sensitivity
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      lo_a   <= in_data.d1 * in_data.sens[19:0];
      hi_a   <= $signed({1'b0, in_data.d1}) * $signed(in_data.sens[39:20]);
      off_a  <= in_data.off;
      temp_a <= in_data.temp;
    end
  end

  // full product, only the part from bit 21 upward is kept
  assign prod = {hi_a[43:0], 20'b0} + {20'b0, lo_a};

  // stage 2
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ps_b   <= $signed(prod[63:21]);
      off_b  <= off_a;
      temp_b <= temp_a;
    end
  end

  assign x_n = 44'(ps_b) - 44'(off_b);

  // stage 3: remove offset, floor shift by 15
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      xp_c   <= $signed(x_n[43:15]);
      temp_c <= temp_b;
    end
  end

  // stage 4: saturate into the output register
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      temperature_centi <= temp_c;
      if (xp_c > 29'(PRESS_MAX)) begin
        pressure_pa <= 27'(PRESS_MAX);
      end else if (xp_c < 29'(PRESS_MIN)) begin
        pressure_pa <= 27'(PRESS_MIN);
      end else begin
        pressure_pa <= xp_c[26:0];
      end
    end
  end

endmodule

FILE: src/baro_second_order_compensation.sv
// ----------------------------------------------------------------------------
// baro_second_order_compensation
// Barometer compensation: raw pressure and temperature conversions in,
// compensated temperature (0.01 C) and pressure (Pa) out.
//
//   channel  | direction | handshake                  | payload
//   sample   | in        | sample_valid / sample_stall | press_raw, temp_raw
//   result   | out       | result_valid / result_stall | temperature_centi, pressure_pa
//   cfg      | in        | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// One transaction per cycle sustained while result_stall is low; each result
// passes three first-order, three correction and four pressure stages (the
// 64-bit D1 times sensitivity product is formed from two partial products in
// the first pressure stage).
// Reset clears all stage valid bits and the six coefficients to zero.
// A stalled result holds each stage that is full; empty stages keep filling,
// so sample_stall rises only once the whole pipeline is occupied.
// cfg_ready is always high; indexes beyond the six coefficients are dropped.
// ----------------------------------------------------------------------------
module baro_second_order_compensation import bsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic        [23:0] press_raw,
  input  logic        [23:0] temp_raw,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [18:0] temperature_centi,
  output logic signed [26:0] pressure_pa,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [15:0] cfg_data
);

  coef_t  coef;
  logic   front_ready;
  logic   front_valid;
  front_t front_data;
  logic   corr_ready;
  logic   corr_valid;
  corr_t  corr_data;
  logic   press_ready;

  assign cfg_ready    = 1'b1;
  assign sample_stall = !front_ready;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_C1:  coef.c1 <= cfg_data;
        REG_C2:  coef.c2 <= cfg_data;
        REG_C3:  coef.c3 <= cfg_data;
        REG_C4:  coef.c4 <= cfg_data;
        REG_C5:  coef.c5 <= cfg_data;
        REG_C6:  coef.c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  // first-order stages
  bsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (sample_valid),
    .in_ready  (front_ready),
    .press_raw (press_raw),
    .temp_raw  (temp_raw),
    .out_valid (front_valid),
    .out_ready (corr_ready),
    .out_data  (front_data)
  );

  // second-order correction stages
  bsc_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (corr_ready),
    .in_data   (front_data),
    .out_valid (corr_valid),
    .out_ready (press_ready),
    .out_data  (corr_data)
  );

  // pressure stages and output register
  bsc_press u_press (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (corr_valid),
    .in_ready          (press_ready),
    .in_data           (corr_data),
    .out_valid         (result_valid),
    .out_ready         (!result_stall),
    .temperature_centi (temperature_centi),
    .pressure_pa       (pressure_pa)
  );

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a coefficient write lands in its register
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_C6 |=> coef.c6 == $past(cfg_data))
    else $error("coefficient write lost");

  // temperature stays within its saturation range
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (temperature_centi <= 19'(TEMP_MAX) &&
                      temperature_centi >= 19'(TEMP_MIN)))
    else $error("temperature out of range");

endmodule

FILE: dv/baro_second_order_compensation_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// baro_second_order_compensation_tb
// Drives raw pressure/temperature conversion pairs through the compensation
// pipeline under several coefficient sets. A behavioral compensation model
// predicts each reading, and every result transaction is compared in order.
// Covers the reset coefficients, warm, cold and very cold corners, low
// temperature saturation, dropped writes to spare register indexes, and random
// traffic with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module baro_second_order_compensation_tb;
  import bsc_pkg::*;

  // register indexes past the six coefficients
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int PIPE_DEPTH   = 10;
  localparam int DRAIN_CYCLES = 4 * PIPE_DEPTH;
  localparam int SETS_PER_PHASE = 5;
  localparam int ITEMS_PER_SET  = 70;

  // datasheet example coefficients
  localparam coef_t TYPICAL_COEFS = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                      c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};

  typedef struct {
    logic signed [18:0] temperature;
    logic signed [26:0] pressure;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               sample_valid;
  logic               sample_stall;
  logic        [23:0] press_raw;
  logic        [23:0] temp_raw;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [18:0] temperature_centi;
  logic signed [26:0] pressure_pa;
  logic               cfg_valid;
  logic               cfg_ready;
  logic        [2:0]  cfg_index;
  logic        [15:0] cfg_data;

  coef_t    coefs = '0;
  reading_t expected_readings[$];
  int       fail_count = 0;
  int       idle_pct;
  int       stall_pct;

  baro_second_order_compensation uut (
    .clk               (clk),
    .rst               (rst),
    .sample_valid      (sample_valid),
    .sample_stall      (sample_stall),
    .press_raw         (press_raw),
    .temp_raw          (temp_raw),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .temperature_centi (temperature_centi),
    .pressure_pa       (pressure_pa),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // clock
  always #5 clk = ~clk;

  // compensated reading for one conversion pair, 64-bit signed throughout
  function automatic reading_t compensate(input coef_t c, input logic [23:0] d1,
                                          input logic [23:0] d2);
    longint   dt;
    longint   temp;
    longint   off;
    longint   sens;
    longint   sq;
    longint   cold;
    longint   press;
    reading_t r;
    dt   = longint'(d2) - (longint'(c.c5) << 8);
    temp = TEMP_REF + ((dt * longint'(c.c6)) >>> 23);
    off  = (longint'(c.c2) << 16) + ((longint'(c.c4) * dt) >>> 7);
    sens = (longint'(c.c1) << 15) + ((longint'(c.c3) * dt) >>> 8);
    // second-order correction below 20.00 C
    if (temp < TEMP_REF) begin
      sq   = (temp - TEMP_REF) * (temp - TEMP_REF);
      off  = off - ((5 * sq) >>> 1);
      sens = sens - ((5 * sq) >>> 2);
      // extra term below -15.00 C
      if (temp < TEMP_COLD) begin
        cold = (temp - TEMP_COLD) * (temp - TEMP_COLD);
        off  = off - 7 * cold;
        sens = sens - ((11 * cold) >>> 1);
      end
      temp = temp - ((dt * dt) >>> 31);
    end
    press = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
    // saturate to the field ranges
    if (temp > TEMP_MAX) temp = TEMP_MAX;
    else if (temp < TEMP_MIN) temp = TEMP_MIN;
    if (press > PRESS_MAX) press = PRESS_MAX;
    else if (press < PRESS_MIN) press = PRESS_MIN;
    r.temperature = temp[18:0];
    r.pressure    = press[26:0];
    return r;
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // result check, register shadow and prediction, in that order each edge
  always @(posedge clk) begin
    reading_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, temperature_centi %0d pressure_pa %0d",
                   $time, temperature_centi, pressure_pa);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          if (temperature_centi !== want.temperature) begin
            $display("%0t: temperature_centi expected %0d, got %0d",
                     $time, want.temperature, temperature_centi);
            fail_count++;
          end
          if (pressure_pa !== want.pressure) begin
            $display("%0t: pressure_pa expected %0d, got %0d",
                     $time, want.pressure, pressure_pa);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_C1: coefs.c1 = cfg_data;
          REG_C2: coefs.c2 = cfg_data;
          REG_C3: coefs.c3 = cfg_data;
          REG_C4: coefs.c4 = cfg_data;
          REG_C5: coefs.c5 = cfg_data;
          REG_C6: coefs.c6 = cfg_data;
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) begin
        expected_readings.push_back(compensate(coefs, press_raw, temp_raw));
      end
    end
  end

  // one sample transaction, with random sender gaps; starts and ends at negedge
  task automatic send_sample(input logic [23:0] d1, input logic [23:0] d2);
    while ($urandom_range(99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    press_raw    <= d1;
    temp_raw     <= d2;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
  endtask

  // hold off the sender until every predicted reading has come back
  task automatic wait_results_done;
    sample_valid <= 1'b0;
    do @(negedge clk); while (expected_readings.size() != 0);
  endtask

  // one register write transaction
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_coefs(input coef_t c);
    write_reg(REG_C1, c.c1);
    write_reg(REG_C2, c.c2);
    write_reg(REG_C3, c.c3);
    write_reg(REG_C4, c.c4);
    write_reg(REG_C5, c.c5);
    write_reg(REG_C6, c.c6);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // random coefficient sets, each followed by a burst of conversion pairs
  task automatic run_random_phase;
    coef_t       c;
    int          span;
    int          d2v;
    logic [23:0] d1;
    for (int s = 0; s < SETS_PER_PHASE; s++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          c    = TYPICAL_COEFS;
          c.c1 = c.c1 + 16'($urandom_range(4000)) - 16'd2000;
          c.c2 = c.c2 + 16'($urandom_range(4000)) - 16'd2000;
          c.c3 = c.c3 + 16'($urandom_range(4000)) - 16'd2000;
          c.c4 = c.c4 + 16'($urandom_range(4000)) - 16'd2000;
          c.c5 = c.c5 + 16'($urandom_range(4000)) - 16'd2000;
          c.c6 = c.c6 + 16'($urandom_range(4000)) - 16'd2000;
        end
        6, 7, 8: c = {$urandom, $urandom, $urandom};
        default: begin
          // each coefficient at zero or full scale
          for (int k = 0; k < 6; k++) c = {c[79:0], {16{1'($urandom_range(1))}}};
        end
      endcase
      load_coefs(c);
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        // let the whole pipe empty once per phase
        if (s == 0 && i == ITEMS_PER_SET / 2) wait_results_done;
        case ($urandom_range(9))
          0: d1 = '0;
          1: d1 = '1;
          2, 3: d1 = 24'(9085466 + int'($urandom_range(2000000)) - 1000000);
          default: d1 = 24'($urandom);
        endcase
        case ($urandom_range(9))
          0, 1, 2: d2v = int'($urandom_range(16777215));
          3: d2v = $urandom_range(1) ? 16777215 : 0;
          default: begin
            // near the reference temperature, at a random spread
            span = 1 << $urandom_range(23, 8);
            d2v  = (int'(c.c5) << 8) + int'($urandom_range(2 * span)) - span;
            if (d2v < 0) d2v = 0;
            else if (d2v > 16777215) d2v = 16777215;
          end
        endcase
        send_sample(d1, 24'(d2v));
      end
      wait_results_done;
    end
  endtask

  // coefficients stay zero after reset
  task automatic test_reset_coefs;
    send_sample(24'd0, 24'd0);
    send_sample('1, '1);
    send_sample(24'h5A5A5A, 24'hA5A5A5);
    wait_results_done;
  endtask

  // warm, cold and very cold points, full-scale and zero coefficients
  task automatic test_directed_corners;
    load_coefs(TYPICAL_COEFS);
    send_sample(24'd9085466, 24'd8569150);  // warm, first order only
    send_sample(24'd9085466, 24'd8566784);  // dt zero, exactly 20.00 C
    send_sample(24'd9085466, 24'd8566783);  // just under 20.00 C
    send_sample(24'd9085466, 24'd8000000);  // cold, no extra term
    send_sample(24'd9085466, 24'd7000000);  // below -15.00 C
    send_sample(24'd0, 24'd0);
    send_sample('1, '1);
    send_sample('1, 24'd0);
    wait_results_done;
    // full-scale coefficients, d2 of zero drives temperature below range
    load_coefs('1);
    send_sample(24'd0, 24'd0);
    send_sample('1, '1);
    send_sample('1, 24'd0);
    send_sample(24'd0, '1);
    wait_results_done;
    // writes past the last coefficient must be dropped
    load_coefs('0);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    cfg_valid <= 1'b0;
    @(negedge clk);
    send_sample('1, 24'd0);
    send_sample(24'd123456, '1);
    wait_results_done;
  endtask

  task automatic test_random_sender_light;
    idle_pct  = 9;
    stall_pct = 54;
    run_random_phase;
  endtask

  task automatic test_random_receiver_light;
    idle_pct  = 54;
    stall_pct = 9;
    run_random_phase;
  endtask

  task automatic test_random_full_rate;
    idle_pct  = 0;
    stall_pct = 0;
    run_random_phase;
  endtask

  // test sequence
  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    press_raw    = '0;
    temp_raw     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_C1;
    cfg_data     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_coefs;
    test_directed_corners;
    test_random_sender_light;
    test_random_receiver_light;
    test_random_full_rate;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_readings.size() != 0) begin
      $display("%0t: %0d expected readings never arrived", $time, expected_readings.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
